### rtl/vrts_pkg.sv
// Package for the vertex rotate, translate and screen-map block.
// Holds field widths, register indexes, the configuration struct and the sine table.
// No dependencies; every other file of the block imports it.
package vrts_pkg;

    localparam int VERT_W         = 16;
    localparam int OUT_W          = 18;
    localparam int ANGLE_W        = 9;
    localparam int SCREEN_W       = 12;
    localparam int ORIGIN_W       = SCREEN_W - 1;
    localparam int OFFSET_W       = 16;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 40;

    // Sine and cosine are signed fixed point with this many fraction bits.
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TBL_W          = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int PROD_W         = VERT_W + TRIG_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int ROT_W          = SUM_W - TRIG_FRAC_BITS;
    localparam int ACC_W          = ROT_W + 2;

    // Table build works in unsigned Q2.30.
    localparam int TBL_Q          = 30;
    localparam int TBL_SH         = TBL_Q - TRIG_FRAC_BITS;
    localparam int TBL_DEPTH      = 91;
    localparam int TBL_IDX_W      = 7;

    localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

    localparam logic [SCREEN_W-1:0] SCREEN_RESET = SCREEN_W'(800);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ANGLE    = 3'd0,
        REG_OFFSET_X = 3'd1,
        REG_OFFSET_Y = 3'd2,
        REG_SCREEN_W = 3'd3,
        REG_SCREEN_H = 3'd4
    } reg_idx_t;

    // Settings the datapath sees, with sine and cosine already looked up.
    typedef struct packed {
        logic signed [TRIG_W-1:0]   sin_val;
        logic signed [TRIG_W-1:0]   cos_val;
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic [ORIGIN_W-1:0]        origin_x;
        logic [ORIGIN_W-1:0]        origin_y;
    } cfg_t;

    typedef logic [TBL_W-1:0] sin_tbl_t [0:TBL_DEPTH-1];

    // Sine of 0..90 degrees by a Taylor series in unsigned Q2.30, rounded
    // to the trig fraction width. Evaluated once at elaboration. Term k is
    // divided by (2k)(2k+1).
    function automatic sin_tbl_t build_sin_tbl();
        sin_tbl_t          tbl;
        longint unsigned   r;
        longint unsigned   r2;
        longint unsigned   term;
        longint unsigned   sum;
        longint unsigned   prod;
        for (int d = 0; d < TBL_DEPTH; d++)
        begin
            r    = (longint'(d) * 64'd31415926) << TBL_Q;
            r    = (r + 64'd900000000) / 64'd1800000000;
            r2   = (r * r) >> TBL_Q;
            term = r;
            sum  = r;
            for (int k = 1; k < 20; k++)
            begin
                // Once the term reaches zero it stays zero.
                prod = (term * r2) >> TBL_Q;
                unique case (k)
                    1:       term = prod / 64'd6;
                    2:       term = prod / 64'd20;
                    3:       term = prod / 64'd42;
                    4:       term = prod / 64'd72;
                    5:       term = prod / 64'd110;
                    6:       term = prod / 64'd156;
                    7:       term = prod / 64'd210;
                    8:       term = prod / 64'd272;
                    9:       term = prod / 64'd342;
                    10:      term = prod / 64'd420;
                    11:      term = prod / 64'd506;
                    12:      term = prod / 64'd600;
                    13:      term = prod / 64'd702;
                    14:      term = prod / 64'd812;
                    15:      term = prod / 64'd930;
                    16:      term = prod / 64'd1056;
                    17:      term = prod / 64'd1190;
                    18:      term = prod / 64'd1332;
                    19:      term = prod / 64'd1482;
                    default: term = '0;
                endcase
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            sum    = (sum + (64'd1 << (TBL_SH - 1))) >> TBL_SH;
            tbl[d] = sum[TBL_W-1:0];
        end
        return tbl;
    endfunction

    localparam sin_tbl_t SIN_TBL = build_sin_tbl();

    // Reduce an angle of 0..511 degrees to 0..359.
    function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] w;
        w = (a >= DEG_360) ? a - DEG_360 : a;
        return w;
    endfunction

    // Sine of 0..359 degrees by quadrant symmetry on the table.
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]   m;
        logic [TBL_IDX_W-1:0] idx;
        logic                 neg;
        logic [TRIG_W-1:0]    mag;
        priority if (a < DEG_90)
        begin
            m   = a;
            neg = 1'b0;
        end
        else if (a < DEG_180)
        begin
            m   = DEG_180 - a;
            neg = 1'b0;
        end
        else if (a < DEG_270)
        begin
            m   = a - DEG_180;
            neg = 1'b1;
        end
        else
        begin
            m   = DEG_360 - a;
            neg = 1'b1;
        end
        idx = m[TBL_IDX_W-1:0];
        mag = TRIG_W'(SIN_TBL[idx]);
        return neg ? signed'(-mag) : signed'(mag);
    endfunction

    // Cosine as the sine of the angle plus a quarter turn.
    function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] c;
        c = (a >= DEG_270) ? a - DEG_270 : a + DEG_90;
        return sin_deg(c);
    endfunction

endpackage

### rtl/vertex_rotate_translate_to_screen.sv
// Top level of the vertex rotate, translate and screen-map block.
// Instantiates vrts_cfg and vrts_datapath; depends on vrts_pkg.
//
// Each request on the slave stream is one model-space vertex. The block rotates it
// counterclockwise by the configured whole-degree angle, truncating toward zero,
// adds the configured offsets and maps it to screen pixels with y pointing down
// (origin at half the screen width and height, rounded down). Every vertex gives
// exactly one screen point, wrapped to 18 bits with no saturation. The block takes
// one vertex per clock cycle while the output is not stalled. An accepted vertex
// sits in the vertex input register until the result register can move; its screen
// point is then loaded into the result register and m_tvalid rises, and the point is
// held there until taken. The four 16 by 18 multiplies, the sums and the offset
// adds lie between the two registers. s_tready is high while the input register is
// empty or the result register is empty or being taken, so one more vertex is still
// accepted into the empty input register while a finished point waits. Sine and
// cosine come from a 91-entry quarter-wave constant table in unsigned Q1.16, looked up
// once when the angle register is written, so a rotation can differ by one
// from exact arithmetic. Angles of 360 and above wrap modulo 360, and writes to
// register indexes above 4 are ignored. Configuration is meant to change only
// while no vertex is in flight; cfg_ready is always high.
module vertex_rotate_translate_to_screen
    import vrts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Vertex stream in.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    // Screen point stream out.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [17:0] screen_x, [35:18] screen_y, rest zero
);

    cfg_t                     cfg;
    logic signed [OUT_W-1:0]  screen_x;
    logic signed [OUT_W-1:0]  screen_y;

    assign cfg_ready = 1'b1;

    vrts_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    vrts_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vertex_x  (signed'(s_tdata[VERT_W-1:0])),
        .vertex_y  (signed'(s_tdata[2*VERT_W-1:VERT_W])),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

    // Pack the two results from the lowest bit up, padded with zeros.
    assign m_tdata = {{(M_TDATA_W - 2*OUT_W){1'b0}}, screen_y, screen_x};

endmodule

### rtl/vrts_cfg.sv
// Configuration registers of the vertex transform block.
// Looks up sine and cosine when the angle is written; depends on vrts_pkg.
module vrts_cfg
    import vrts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_ADDR_W-1:0] wr_addr,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic signed [TRIG_W-1:0]   sin_reg,      sin_next;
    logic signed [TRIG_W-1:0]   cos_reg,      cos_next;
    logic signed [OFFSET_W-1:0] offset_x_reg, offset_x_next;
    logic signed [OFFSET_W-1:0] offset_y_reg, offset_y_next;
    logic [SCREEN_W-1:0]        width_reg,    width_next;
    logic [SCREEN_W-1:0]        height_reg,   height_next;
    logic [ANGLE_W-1:0]         angle;

    assign angle = wrap_angle(wr_data[ANGLE_W-1:0]);

    always_comb
    begin
        sin_next      = sin_reg;
        cos_next      = cos_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_addr))
                REG_ANGLE:
                begin
                    sin_next = sin_deg(angle);
                    cos_next = cos_deg(angle);
                end
                REG_OFFSET_X: offset_x_next = signed'(wr_data[OFFSET_W-1:0]);
                REG_OFFSET_Y: offset_y_next = signed'(wr_data[OFFSET_W-1:0]);
                REG_SCREEN_W: width_next    = wr_data[SCREEN_W-1:0];
                REG_SCREEN_H: height_next   = wr_data[SCREEN_W-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                    sin_next = sin_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg      <= sin_deg('0);
            cos_reg      <= cos_deg('0);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            width_reg    <= SCREEN_RESET;
            height_reg   <= SCREEN_RESET;
        end
        else
        begin
            sin_reg      <= sin_next;
            cos_reg      <= cos_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
    end

    always_comb
    begin
        cfg.sin_val  = sin_reg;
        cfg.cos_val  = cos_reg;
        cfg.offset_x = offset_x_reg;
        cfg.offset_y = offset_y_reg;
        cfg.origin_x = width_reg[SCREEN_W-1:1];
        cfg.origin_y = height_reg[SCREEN_W-1:1];
    end

endmodule

### rtl/vrts_datapath.sv
// Two-register datapath: vertex input register, rotate/translate logic, result register.
// Depends on vrts_pkg for widths and the cfg_t struct.
module vrts_datapath
    import vrts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VERT_W-1:0] vertex_x,
    input  logic signed [VERT_W-1:0] vertex_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  screen_x,
    output logic signed [OUT_W-1:0]  screen_y
);

    localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    logic                     vld_in_reg,  vld_in_next;
    logic                     vld_out_reg, vld_out_next;
    logic signed [VERT_W-1:0] x_reg, y_reg;
    logic signed [OUT_W-1:0]  sx_reg, sy_reg;
    logic                     adv;
    logic                     load_in;

    logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [SUM_W-1:0]         tr_x, tr_y;
    logic signed [ROT_W-1:0]  rx, ry;
    logic [ACC_W-1:0]         acc_x, acc_y;

    // The result register moves whenever it is empty or being drained.
    assign adv      = !vld_out_reg || out_ready;
    assign in_ready = adv || !vld_in_reg;
    assign load_in  = in_valid && in_ready;

    always_comb
    begin
        vld_in_next  = vld_in_reg;
        vld_out_next = vld_out_reg;
        if (adv)
            vld_out_next = vld_in_reg;
        if (in_ready)
            vld_in_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_in_reg  <= 1'b0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_in_reg  <= vld_in_next;
            vld_out_reg <= vld_out_next;
        end
    end

    // Rotation products, then truncation of the sums toward zero.
    always_comb
    begin
        p_xc  = x_reg * cfg.cos_val;
        p_ys  = y_reg * cfg.sin_val;
        p_xs  = x_reg * cfg.sin_val;
        p_yc  = y_reg * cfg.cos_val;
        sum_x = SUM_W'(p_xc) - SUM_W'(p_ys);
        sum_y = SUM_W'(p_xs) + SUM_W'(p_yc);
        tr_x  = sum_x + (sum_x[SUM_W-1] ? TRUNC_BIAS : '0);
        tr_y  = sum_y + (sum_y[SUM_W-1] ? TRUNC_BIAS : '0);
        rx    = signed'(tr_x[SUM_W-1:TRIG_FRAC_BITS]);
        ry    = signed'(tr_y[SUM_W-1:TRIG_FRAC_BITS]);
        acc_x = ACC_W'(cfg.origin_x) + ACC_W'(rx) + ACC_W'(cfg.offset_x);
        acc_y = ACC_W'(cfg.origin_y) - (ACC_W'(ry) + ACC_W'(cfg.offset_y));
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            x_reg <= vertex_x;
            y_reg <= vertex_y;
        end
        if (adv && vld_in_reg)
        begin
            sx_reg <= signed'(acc_x[OUT_W-1:0]);
            sy_reg <= signed'(acc_y[OUT_W-1:0]);
        end
    end

    assign out_valid = vld_out_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

endmodule

### rtl/vrts_checker.sv
// Port-level checker for the vertex transform block, bound to the top level.
// Depends on vrts_pkg for port widths.
module vrts_checker
    import vrts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // With the result register empty, the block must take a new vertex.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // An accepted vertex reaches the output when m_tready does not hold it back.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted vertex did not produce a result");

    // Padding bits above the two results stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:2*OUT_W] == '0)
        else $error("nonzero padding in result");

endmodule

bind vertex_rotate_translate_to_screen vrts_checker u_vrts_checker (.*);
